@@ hw/rtl/bmx_pkg.sv @@
// shared types and constants for the binary trie maximum xor block
package bmx_pkg;

    localparam int VALUE_W  = 31;
    localparam int STATUS_W = 2;

    typedef enum logic [0:0] {
        ACT_INSERT = 1'b0,
        ACT_QUERY  = 1'b1
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 2'd0,
        ST_ANSWERED = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_CHECK,
        S_LINK,
        S_ALLOC,
        S_FIN
    } t_state;

endpackage

@@ hw/rtl/bmx_ram.sv @@
// generic single write port ram with registered read
module bmx_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/binary_trie_max_xor.sv @@
// top level: binary trie of values with insert and maximum xor query
//
// input channel: i_valid, i_stall out as o_stall, fields i_action and i_value.
// action insert adds the value's key path to the trie; action query returns
// the greatest xor of the value with any stored value.
// output channel: o_valid, i_stall, fields o_status and o_max_xor; each item
// gives exactly one result item.
// one item is in work at a time; o_stall is high from acceptance until the
// result has moved into the output register.
// a query makes one node store read per trie level.
// an insert makes one read per existing level; a duplicate insert does no more,
// a dropped insert adds a full check, and a stored insert adds a full check,
// one parent link write and one write per new node.
// a finished result waits in the output register while the receiver stalls;
// the next item is accepted meanwhile, and its own result waits in S_FIN.
// reset empties the trie (root links null, next free node one) at once;
// no clearing pass is needed since each node is written when allocated.
module binary_trie_max_xor #(
    parameter int KEY_BITS   = 32,
    parameter int NODE_COUNT = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_action,
    input  logic [bmx_pkg::VALUE_W-1:0]   i_value,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [bmx_pkg::STATUS_W-1:0]  o_status,
    output logic [bmx_pkg::VALUE_W-1:0]   o_max_xor
);

    import bmx_pkg::*;

    localparam int NW    = $clog2(NODE_COUNT);
    localparam int LW    = 2 * NW;
    localparam int LVL_W = $clog2(KEY_BITS);
    localparam int CW    = NW + 2;
    localparam logic [LVL_W-1:0] LVL_LAST = LVL_W'(KEY_BITS - 1);

    t_state            r_state, n_state;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic [KEY_BITS-1:0] r_acc, n_acc;
    logic [LVL_W-1:0]  r_level, n_level;
    logic [NW-1:0]     r_cur, n_cur;
    logic              r_at_root, n_at_root;
    logic [LW-1:0]     r_links, n_links;
    logic [LW-1:0]     r_root, n_root;
    logic [NW:0]       r_next, n_next;
    t_action           r_action, n_action;
    t_status           r_status, n_status;
    logic              r_ovalid, n_ovalid;
    t_status           r_ostatus, n_ostatus;
    logic [VALUE_W-1:0] r_oxor, n_oxor;

    logic [KEY_BITS-1:0] w_key;
    logic [VALUE_W-1:0]  w_acc_out;
    logic [LW-1:0]     w_rdata;
    logic [LW-1:0]     w_cur_links;
    logic              w_bit;
    logic [NW-1:0]     w_same;
    logic [NW-1:0]     w_opp;
    logic              w_found;
    logic [NW-1:0]     w_nx;
    logic              w_last;
    logic [NW-1:0]     w_new_idx;
    logic [NW:0]       w_next_inc;
    logic [NW-1:0]     w_inc_idx;
    logic [LW-1:0]     w_upd;
    logic [CW-1:0]     w_need;
    logic [CW-1:0]     w_sum;
    logic              w_we;
    logic [NW-1:0]     w_waddr;
    logic [LW-1:0]     w_wdata;
    logic [NW-1:0]     w_raddr;

    // key path bits: key bits at positions 31 and above read as zero
    for (genvar gi = 0; gi < KEY_BITS; gi++) begin : g_key
        if (gi < VALUE_W) begin : g_val
            assign w_key[gi] = i_value[gi];
        end else begin : g_zero
            assign w_key[gi] = 1'b0;
        end
    end

    for (genvar gj = 0; gj < VALUE_W; gj++) begin : g_out
        if (gj < KEY_BITS) begin : g_acc
            assign w_acc_out[gj] = r_acc[gj];
        end else begin : g_zero
            assign w_acc_out[gj] = 1'b0;
        end
    end

    bmx_ram #(
        .WIDTH (LW),
        .DEPTH (NODE_COUNT)
    ) u_nodes (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // child link 0 in the low half, child link 1 in the high half
    assign w_cur_links = r_at_root ? r_root : w_rdata;
    assign w_bit       = r_key[KEY_BITS-1];
    assign w_same      = w_bit ? w_cur_links[LW-1:NW] : w_cur_links[NW-1:0];
    assign w_opp       = w_bit ? w_cur_links[NW-1:0] : w_cur_links[LW-1:NW];
    assign w_found     = (w_opp != '0);
    assign w_nx        = w_found ? w_opp : w_same;
    assign w_last      = (r_level == LVL_LAST);
    assign w_new_idx   = r_next[NW-1:0];
    assign w_next_inc  = r_next + 1'b1;
    assign w_inc_idx   = w_next_inc[NW-1:0];
    assign w_upd       = w_bit ? {w_new_idx, r_links[NW-1:0]} : {r_links[LW-1:NW], w_new_idx};
    assign w_need      = CW'(KEY_BITS) - CW'(r_level);
    assign w_sum       = CW'(r_next) + w_need;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_root   <= '0;
            r_next   <= (NW+1)'(1);
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_root   <= n_root;
            r_next   <= n_next;
            r_ovalid <= n_ovalid;
        end
        r_key     <= n_key;
        r_acc     <= n_acc;
        r_level   <= n_level;
        r_cur     <= n_cur;
        r_at_root <= n_at_root;
        r_links   <= n_links;
        r_action  <= n_action;
        r_status  <= n_status;
        r_ostatus <= n_ostatus;
        r_oxor    <= n_oxor;
    end

    always_comb begin
        n_state   = r_state;
        n_key     = r_key;
        n_acc     = r_acc;
        n_level   = r_level;
        n_cur     = r_cur;
        n_at_root = r_at_root;
        n_links   = r_links;
        n_root    = r_root;
        n_next    = r_next;
        n_action  = r_action;
        n_status  = r_status;
        n_ovalid  = r_ovalid && i_stall;
        n_ostatus = r_ostatus;
        n_oxor    = r_oxor;
        w_we      = 1'b0;
        w_waddr   = w_new_idx;
        w_wdata   = '0;
        w_raddr   = r_cur;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_key     = w_key;
                    n_acc     = '0;
                    n_level   = '0;
                    n_cur     = '0;
                    n_at_root = 1'b1;
                    n_action  = t_action'(i_action);
                    if (t_action'(i_action) == ACT_QUERY && r_root == '0) begin
                        n_status = ST_EMPTY;
                        n_state  = S_FIN;
                    end else begin
                        n_state = S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (r_action == ACT_QUERY) begin
                    w_raddr   = w_nx;
                    n_cur     = w_nx;
                    n_at_root = 1'b0;
                    n_key     = {r_key[KEY_BITS-2:0], 1'b0};
                    n_acc     = {r_acc[KEY_BITS-2:0], w_found};
                    n_level   = r_level + 1'b1;
                    if (w_last) begin
                        n_status = ST_ANSWERED;
                        n_state  = S_FIN;
                    end
                end else if (w_same == '0) begin
                    n_links = w_cur_links;
                    n_state = S_CHECK;
                end else begin
                    w_raddr   = w_same;
                    n_cur     = w_same;
                    n_at_root = 1'b0;
                    n_key     = {r_key[KEY_BITS-2:0], 1'b0};
                    n_level   = r_level + 1'b1;
                    if (w_last) begin
                        n_status = ST_INSERTED;
                        n_state  = S_FIN;
                    end
                end
            end
            S_CHECK: begin
                if (w_sum > CW'(NODE_COUNT)) begin
                    n_status = ST_FULL;
                    n_state  = S_FIN;
                end else begin
                    n_state = S_LINK;
                end
            end
            S_LINK: begin
                if (r_at_root) begin
                    n_root = w_upd;
                end else begin
                    w_we    = 1'b1;
                    w_waddr = r_cur;
                    w_wdata = w_upd;
                end
                n_state = S_ALLOC;
            end
            S_ALLOC: begin
                w_we    = 1'b1;
                w_waddr = w_new_idx;
                if (w_last) begin
                    w_wdata = '0;
                end else if (r_key[KEY_BITS-2]) begin
                    w_wdata = {w_inc_idx, {NW{1'b0}}};
                end else begin
                    w_wdata = {{NW{1'b0}}, w_inc_idx};
                end
                n_next  = w_next_inc;
                n_key   = {r_key[KEY_BITS-2:0], 1'b0};
                n_level = r_level + 1'b1;
                if (w_last) begin
                    n_status = ST_INSERTED;
                    n_state  = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_status;
                    n_oxor    = (r_status == ST_ANSWERED) ? w_acc_out : '0;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_stall   = (r_state != S_IDLE);
    assign o_valid   = r_ovalid;
    assign o_status  = r_ostatus;
    assign o_max_xor = r_oxor;

`ifndef SYNTH
    a_next_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next <= (NW+1)'(NODE_COUNT))
        else $error("next free node beyond node store");

    a_alloc_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ALLOC |-> r_next < (NW+1)'(NODE_COUNT))
        else $error("node allocated outside node store");

    a_empty_no_nodes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_root == '0 |-> r_next == (NW+1)'(1))
        else $error("empty root with allocated nodes");

    a_xor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_ANSWERED |-> o_max_xor == '0)
        else $error("nonzero xor on a result that is not an answer");

    a_full_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CHECK && w_sum > CW'(NODE_COUNT) |=> $stable(r_next) && $stable(r_root))
        else $error("dropped insert changed the trie");
`endif

endmodule
